@@ hdl/connection_credit_tracker_top_macros.svh @@
// assertion macros used by the credit tracker rtl
// depends on nothing; included by files that carry concurrent assertions
`ifndef CONNECTION_CREDIT_TRACKER_TOP_MACROS_SVH
`define CONNECTION_CREDIT_TRACKER_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define CCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define CCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/cct_pkg.sv @@
// types and codes for the connection credit tracker
// depends on nothing; used by cct_cell and connection_credit_tracker_top
`timescale 1ns / 1ps
`default_nettype none

package cct_pkg;

   localparam int HANDLE_W   = 12;
   localparam int COUNT_W    = 16;
   localparam int STATUS_W   = 8;
   localparam int CREDIT_W   = 8;
   localparam int CMD_W      = 3;
   localparam int ERR_W      = 3;
   localparam int CSR_W      = 16;
   // wide enough for tables of up to 64 slots
   localparam int SLOT_IDX_W = 6;

   localparam logic [CMD_W-1:0] CMD_CONNECT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DISCONNECT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_COMPLETED  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEND       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LOOKUP     = 3'd4;

   localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
   localparam logic [ERR_W-1:0] ERR_FULL      = 3'd1;
   localparam logic [ERR_W-1:0] ERR_UNKNOWN   = 3'd2;
   localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 3'd3;
   localparam logic [ERR_W-1:0] ERR_LIMIT     = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [HANDLE_W-1:0] handle;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] event_status;
   } cct_req_type;

   typedef struct packed {
      logic                tracked;
      logic                accepted;
      logic                purge;
      logic [CREDIT_W-1:0] released;
      logic [CREDIT_W-1:0] total_in_flight;
      logic                may_send;
      logic [ERR_W-1:0]    error;
   } cct_rsp_type;

   // search token that walks the row of slot cells
   typedef struct packed {
      logic                  valid;
      logic [HANDLE_W-1:0]   handle;
      logic                  hit;
      logic [SLOT_IDX_W-1:0] hit_idx;
      logic [CREDIT_W-1:0]   hit_cnt;
      logic                  free;
      logic [SLOT_IDX_W-1:0] free_idx;
   } cct_token_type;

   // slot write broadcast to every cell
   typedef struct packed {
      logic                  en;
      logic [SLOT_IDX_W-1:0] idx;
      logic                  valid;
      logic [HANDLE_W-1:0]   handle;
      logic [CREDIT_W-1:0]   cnt;
   } cct_update_type;

endpackage

`default_nettype wire

@@ hdl/cct_cell.sv @@
// one table slot: link handle, in-flight count, and one stage of the search token
// depends on cct_pkg
`timescale 1ns / 1ps
`default_nettype none

module cct_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cct_pkg::cct_token_type  token_i,
   input  wire cct_pkg::cct_update_type upd_i,
   output      cct_pkg::cct_token_type  token_o
);
   import cct_pkg::*;

   localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(CELL_INDEX);

   logic                valid_ff, valid_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [CREDIT_W-1:0] cnt_ff, cnt_in;
   cct_token_type       token_ff, token_in;
   logic                match;

   assign match = valid_ff && (handle_ff == token_i.handle);

   always_comb begin
      token_in = token_i;
      if (!token_i.hit && match) begin
         token_in.hit     = 1'b1;
         token_in.hit_idx = MY_IDX;
         token_in.hit_cnt = cnt_ff;
      end
      if (!token_i.free && !valid_ff) begin
         token_in.free     = 1'b1;
         token_in.free_idx = MY_IDX;
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      handle_in = handle_ff;
      cnt_in    = cnt_ff;
      if (upd_i.en && (upd_i.idx == MY_IDX)) begin
         valid_in  = upd_i.valid;
         handle_in = upd_i.handle;
         cnt_in    = upd_i.cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         handle_ff <= '0;
         cnt_ff    <= '0;
         token_ff  <= '0;
      end else begin
         valid_ff  <= valid_in;
         handle_ff <= handle_in;
         cnt_ff    <= cnt_in;
         token_ff  <= token_in;
      end
   end

   assign token_o = token_ff;

endmodule

`default_nettype wire

@@ hdl/connection_credit_tracker_top.sv @@
// top level of the connection credit tracker: command port, limit register,
// row of slot cells and the command execution logic
// depends on cct_pkg, cct_cell and connection_credit_tracker_top_macros.svh
`timescale 1ns / 1ps
`default_nettype none

// usage
//   command channel: a transaction is taken on a clock edge with start high and
//   busy low; req_data holds cmd, handle, count and event_status
//   result channel: rsp_valid is high for exactly one cycle with rsp_data; the
//   receiver cannot stall it, so it must take the result in that cycle
//   csr port: csr_we with csr_wdata writes the controller buffer count; the
//   in-flight limit is derived from it at write time; write only while idle
//   order: one transaction is open at a time; the search token walks the row of
//   slot cells one cell per cycle, and the table update and the result register
//   load happen on the edge where it leaves the last cell
//   busy stays high from the accepting edge until that update edge, so the next
//   transaction may be accepted in the same cycle that the result is shown
//   reset (synchronous, active high) empties every slot, clears the global
//   in-flight count and the limit register (limit zero)

module connection_credit_tracker_top #(
   parameter int MAX_LINKS      = 8,
   parameter int TARGET_BUFFERS = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire cct_pkg::cct_req_type req_data,
   output      logic                 rsp_valid,
   output      cct_pkg::cct_rsp_type rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [15:0]          csr_wdata
);
   import cct_pkg::*;

`include "connection_credit_tracker_top_macros.svh"

   // limit threshold: twice the target, one bit wider than the csr
   localparam logic [CSR_W:0]    TWICE_TARGET = (CSR_W+1)'(2 * TARGET_BUFFERS);
   localparam logic [CREDIT_W-1:0] TARGET_CNT = CREDIT_W'(TARGET_BUFFERS);

   logic                accept;
   logic                busy_ff, busy_in;
   logic                launch_ff;
   cct_req_type         req_ff;
   logic [CREDIT_W-1:0] limit_ff, limit_in;
   logic [CREDIT_W-1:0] global_ff, global_in;
   cct_rsp_type         rsp_ff, rsp_in;
   logic                rsp_valid_ff;
   cct_update_type      upd;
   cct_token_type       chain [0:MAX_LINKS];
   cct_token_type       tok;

   assign accept = start && !busy_ff;

   // limit: half the buffer count when below twice the target, else the target
   always_comb begin
      limit_in = limit_ff;
      if (csr_we) begin
         if ({1'b0, csr_wdata} < TWICE_TARGET) begin
            limit_in = csr_wdata[CREDIT_W:1];
         end else begin
            limit_in = TARGET_CNT;
         end
      end
   end

   // token enters the first cell the cycle after the command is taken
   always_comb begin
      chain[0]          = '0;
      chain[0].valid    = launch_ff;
      chain[0].handle   = req_ff.handle;
   end

   genvar gi;
   generate
      for (gi = 0; gi < MAX_LINKS; gi++) begin : g_cell
         cct_cell #(
            .CELL_INDEX(gi)
         ) u_cell (
            .clock  (clock),
            .reset  (reset),
            .token_i(chain[gi]),
            .upd_i  (upd),
            .token_o(chain[gi+1])
         );
      end
   endgenerate

   assign tok = chain[MAX_LINKS];

   // command execution on the edge where the token leaves the last cell
   always_comb begin
      logic [CREDIT_W-1:0] rel;
      logic                sub_en;
      rel                  = '0;
      sub_en               = 1'b0;
      global_in            = global_ff;
      upd                  = '0;
      rsp_in               = '0;
      rsp_in.tracked       = tok.hit;

      case (req_ff.cmd)
         CMD_CONNECT: begin
            if (req_ff.event_status == '0) begin
               if (!tok.free) begin
                  rsp_in.error = ERR_FULL;
               end else begin
                  upd.en          = tok.valid;
                  upd.idx         = tok.free_idx;
                  upd.valid       = 1'b1;
                  upd.handle      = req_ff.handle;
                  upd.cnt         = '0;
                  rsp_in.accepted = 1'b1;
               end
            end
         end
         CMD_DISCONNECT: begin
            if (!tok.hit) begin
               rsp_in.error = ERR_UNKNOWN;
            end else begin
               rel             = tok.hit_cnt;
               sub_en          = 1'b1;
               upd.en          = tok.valid;
               upd.idx         = tok.hit_idx;
               upd.valid       = 1'b0;
               upd.handle      = '0;
               upd.cnt         = '0;
               rsp_in.purge    = 1'b1;
               rsp_in.accepted = 1'b1;
            end
         end
         CMD_COMPLETED: begin
            if (!tok.hit) begin
               rsp_in.error = ERR_UNKNOWN;
            end else begin
               // more completed than counted: release only what the slot holds
               if (req_ff.count > {{(COUNT_W-CREDIT_W){1'b0}}, tok.hit_cnt}) begin
                  rel          = tok.hit_cnt;
                  rsp_in.error = ERR_UNDERFLOW;
               end else begin
                  rel = req_ff.count[CREDIT_W-1:0];
               end
               sub_en          = 1'b1;
               upd.en          = tok.valid;
               upd.idx         = tok.hit_idx;
               upd.valid       = 1'b1;
               upd.handle      = req_ff.handle;
               upd.cnt         = tok.hit_cnt - rel;
               rsp_in.accepted = 1'b1;
            end
         end
         CMD_SEND: begin
            if (!tok.hit) begin
               rsp_in.error = ERR_UNKNOWN;
            end else if (global_ff >= limit_ff) begin
               rsp_in.error = ERR_LIMIT;
            end else begin
               // global stays below the limit, so no wrap here
               global_in       = global_ff + CREDIT_W'(1);
               upd.en          = tok.valid;
               upd.idx         = tok.hit_idx;
               upd.valid       = 1'b1;
               upd.handle      = req_ff.handle;
               upd.cnt         = (tok.hit_cnt == '1) ? tok.hit_cnt
                                                     : tok.hit_cnt + CREDIT_W'(1);
               rsp_in.accepted = 1'b1;
            end
         end
         default: begin
            // lookup and unused codes change nothing; they report tracked, in-flight total and may_send
         end
      endcase

      // global subtract clamps at zero
      if (sub_en) begin
         if (global_ff < rel) begin
            global_in    = '0;
            rsp_in.error = ERR_UNDERFLOW;
         end else begin
            global_in = global_ff - rel;
         end
      end

      rsp_in.released        = rel;
      rsp_in.total_in_flight = global_in;
      rsp_in.may_send        = (global_in < limit_ff);
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tok.valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         launch_ff    <= 1'b0;
         limit_ff     <= '0;
         global_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         launch_ff    <= accept;
         limit_ff     <= limit_in;
         rsp_valid_ff <= tok.valid;
         if (tok.valid) begin
            global_ff <= global_in;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (tok.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a result strobe is never held
   `CCT_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "rsp_valid held")
   // an accepted transaction keeps the block busy
   `CCT_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, busy_ff, "busy not raised")
   // purge comes only from an accepted disconnect of a tracked link
   `CCT_ASSERT_NOW(a_purge_tracked, clock, reset, rsp_valid && rsp_data.purge,
      rsp_data.tracked && rsp_data.accepted, "purge without tracked link")
   // rejections never count as accepted and release no credits
   `CCT_ASSERT_NOW(a_reject_clean, clock, reset,
      rsp_valid && (rsp_data.error == ERR_FULL || rsp_data.error == ERR_UNKNOWN ||
      rsp_data.error == ERR_LIMIT), !rsp_data.accepted && rsp_data.released == '0,
      "rejected transaction changed credits")
   // the token only reaches the end of the row while a transaction is open
   `CCT_ASSERT_NOW(a_token_busy, clock, reset, tok.valid, busy_ff, "token outside busy")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for connection_credit_tracker_top: directed and random
// commands, csr writes between phases, results checked against a built-in predictor
// depends on cct_pkg and connection_credit_tracker_top
`timescale 1ns / 1ps

module testbench;
   import cct_pkg::*;

   localparam int MAX_LINKS      = 8;
   localparam int TARGET_BUFFERS = 4;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int PHASES         = 7;
   localparam int PHASE_ITEMS    = 155;
   // command codes the block treats like a lookup
   localparam logic [CMD_W-1:0] CMD_RESERVED_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RESERVED_HI = 3'd7;

   // ---------------------------------------------------------------------------
   // credit ledger: mirrors the slot table and predicts one result per command
   // ---------------------------------------------------------------------------
   class credit_ledger;
      logic [CSR_W-1:0]    acl_buffers;
      logic                slot_used[MAX_LINKS];
      logic [HANDLE_W-1:0] slot_link[MAX_LINKS];
      logic [CREDIT_W-1:0] slot_credit[MAX_LINKS];
      logic [CREDIT_W-1:0] in_flight;
      cct_rsp_type         awaited[$];
      int                  failures;

      function new();
         acl_buffers = '0;
         in_flight   = '0;
         failures    = 0;
         for (int i = 0; i < MAX_LINKS; i++) begin
            slot_used[i]   = 1'b0;
            slot_link[i]   = '0;
            slot_credit[i] = '0;
         end
      endfunction

      function void set_buffers(logic [CSR_W-1:0] value);
         acl_buffers = value;
      endfunction

      // half the buffer count when it is short, otherwise the target
      function int unsigned send_limit();
         if (acl_buffers < 2 * TARGET_BUFFERS)
            return acl_buffers >> 1;
         return TARGET_BUFFERS;
      endfunction

      // take credits back from the global count, clamping at zero
      function bit drain_total(logic [CREDIT_W-1:0] amount);
         if (in_flight < amount) begin
            in_flight = '0;
            return 1'b1;
         end
         in_flight = in_flight - amount;
         return 1'b0;
      endfunction

      function void note_command(cct_req_type item);
         int               hit;
         int               free_slot;
         logic [COUNT_W-1:0] drop;
         cct_rsp_type      r;
         hit       = -1;
         free_slot = -1;
         for (int i = 0; i < MAX_LINKS; i++) begin
            if (hit < 0 && slot_used[i] && slot_link[i] == item.handle)
               hit = i;
            if (free_slot < 0 && !slot_used[i])
               free_slot = i;
         end
         r       = '0;
         r.error = ERR_NONE;
         case (item.cmd)
            CMD_CONNECT: begin
               if (item.event_status == '0) begin
                  if (free_slot < 0) begin
                     r.error = ERR_FULL;
                  end else begin
                     slot_used[free_slot]   = 1'b1;
                     slot_link[free_slot]   = item.handle;
                     slot_credit[free_slot] = '0;
                     r.accepted             = 1'b1;
                  end
               end
            end
            CMD_DISCONNECT: begin
               if (hit < 0) begin
                  r.error = ERR_UNKNOWN;
               end else begin
                  r.released = slot_credit[hit];
                  if (drain_total(r.released))
                     r.error = ERR_UNDERFLOW;
                  slot_used[hit]   = 1'b0;
                  slot_link[hit]   = '0;
                  slot_credit[hit] = '0;
                  r.purge          = 1'b1;
                  r.accepted       = 1'b1;
               end
            end
            CMD_COMPLETED: begin
               if (hit < 0) begin
                  r.error = ERR_UNKNOWN;
               end else begin
                  drop = item.count;
                  if (drop > slot_credit[hit]) begin
                     drop    = slot_credit[hit];
                     r.error = ERR_UNDERFLOW;
                  end
                  slot_credit[hit] = slot_credit[hit] - drop[CREDIT_W-1:0];
                  r.released       = drop[CREDIT_W-1:0];
                  if (drain_total(r.released))
                     r.error = ERR_UNDERFLOW;
                  r.accepted = 1'b1;
               end
            end
            CMD_SEND: begin
               if (hit < 0) begin
                  r.error = ERR_UNKNOWN;
               end else if (in_flight >= send_limit()) begin
                  r.error = ERR_LIMIT;
               end else begin
                  in_flight = in_flight + 1'b1;
                  if (slot_credit[hit] != '1)
                     slot_credit[hit] = slot_credit[hit] + 1'b1;
                  r.accepted = 1'b1;
               end
            end
            default: ;
         endcase
         r.tracked         = (hit >= 0);
         r.total_in_flight = in_flight;
         r.may_send        = (in_flight < send_limit());
         awaited.push_back(r);
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] seen);
         if (seen !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, seen);
            failures++;
         end
      endfunction

      function void check_result(cct_rsp_type got);
         cct_rsp_type want;
         if (awaited.size() == 0) begin
            $error("result with no transaction outstanding: %h", got);
            failures++;
            return;
         end
         want = awaited.pop_front();
         check_field("tracked", want.tracked, got.tracked);
         check_field("accepted", want.accepted, got.accepted);
         check_field("purge", want.purge, got.purge);
         check_field("released", want.released, got.released);
         check_field("total_in_flight", want.total_in_flight, got.total_in_flight);
         check_field("may_send", want.may_send, got.may_send);
         check_field("error", want.error, got.error);
      endfunction
   endclass

   // ---------------------------------------------------------------------------
   // clock, dut and monitors
   // ---------------------------------------------------------------------------
   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   cct_req_type     req_data = '0;
   logic            rsp_valid;
   cct_rsp_type     rsp_data;
   logic            csr_we = 1'b0;
   logic [CSR_W-1:0] csr_wdata = '0;

   credit_ledger    ledger = new();
   int              cycle_count = 0;
   bit              idle_enabled = 1'b0;

   // handful of links so that commands mostly land on tracked slots
   logic [HANDLE_W-1:0] link_pool[10] = '{12'h000, 12'hFFF, 12'h001, 12'h800, 12'h555,
                                         12'hAAA, 12'h07F, 12'hF80, 12'h3C3, 12'hC3C};

   always #1 clock = ~clock;

   connection_credit_tracker_top #(
      .MAX_LINKS      (MAX_LINKS),
      .TARGET_BUFFERS (TARGET_BUFFERS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // the receiver never stalls: every strobed result is taken on the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         ledger.check_result(rsp_data);
   end

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // drivers: everything changes on the falling edge, handshakes sampled on the rising
   // ---------------------------------------------------------------------------

   // present one transaction, optionally after an idle burst, and hold it until taken
   task automatic issue_command(input cct_req_type item);
      int gap;
      if (idle_enabled && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 9);
         @(negedge clock);
         start    = 1'b0;
         // payload is junk while start is low; the block must ignore it
         req_data = cct_req_type'({$urandom, $urandom});
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    = 1'b1;
      req_data = item;
      do @(posedge clock); while (busy !== 1'b0);
      ledger.note_command(item);
   endtask

   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] handle,
                               input logic [COUNT_W-1:0] count,
                               input logic [STATUS_W-1:0] status);
      cct_req_type item;
      item.cmd          = cmd;
      item.handle       = handle;
      item.count        = count;
      item.event_status = status;
      issue_command(item);
   endtask

   // drain every outstanding result, let the block settle, then write the buffer count
   task automatic write_buffers(input logic [CSR_W-1:0] value);
      @(negedge clock);
      start = 1'b0;
      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (MAX_LINKS + 2) @(posedge clock);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = value;
      @(posedge clock);
      ledger.set_buffers(value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // mostly well-formed traffic on known links, with some strays and odd counts
   function automatic cct_req_type random_command();
      cct_req_type item;
      int          pick;
      item.count        = COUNT_W'($urandom_range(0, 65535));
      item.event_status = STATUS_W'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 85)
         item.handle = link_pool[$urandom_range(0, 9)];
      else
         item.handle = HANDLE_W'($urandom_range(0, 4095));
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         item.cmd = CMD_CONNECT;
         if ($urandom_range(0, 99) < 80)
            item.event_status = '0;
      end else if (pick < 32) begin
         item.cmd = CMD_DISCONNECT;
      end else if (pick < 52) begin
         item.cmd = CMD_COMPLETED;
         if ($urandom_range(0, 99) < 70)
            item.count = COUNT_W'($urandom_range(0, 3));
      end else if (pick < 87) begin
         item.cmd = CMD_SEND;
      end else if (pick < 95) begin
         item.cmd = CMD_LOOKUP;
      end else begin
         item.cmd = CMD_W'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
      end
      return item;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------
   initial begin
      logic [CSR_W-1:0] phase_buffers[PHASES];
      phase_buffers = '{16'd8, 16'hFFFF, 16'd1, 16'd5, 16'd0, 16'd3, 16'd9};
      // one phase gets a fully random buffer count
      phase_buffers[4] = CSR_W'($urandom_range(0, 65535));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset limit is zero, so nothing may be sent yet
      send_command(CMD_LOOKUP, 12'h000, 16'h0000, 8'h00);
      send_command(CMD_SEND, 12'h000, 16'h0000, 8'h00);        // unknown link
      send_command(CMD_DISCONNECT, 12'hFFF, 16'hFFFF, 8'hFF);  // unknown link
      send_command(CMD_COMPLETED, 12'hABC, 16'h0001, 8'h00);   // unknown link
      send_command(CMD_CONNECT, 12'hFFF, 16'h0000, 8'hFF);     // failed connect ignored
      send_command(CMD_CONNECT, 12'hFFF, 16'h0000, 8'h00);
      send_command(CMD_SEND, 12'hFFF, 16'h0000, 8'h00);        // limit of zero

      write_buffers(16'd8);
      // fill the table, one link stored twice
      for (int i = 0; i < MAX_LINKS - 1; i++)
         send_command(CMD_CONNECT, (i == 3) ? 12'hFFF : HANDLE_W'(i), 16'h0000, 8'h00);
      send_command(CMD_CONNECT, 12'h123, 16'h0000, 8'h00);     // table full
      // one past the global limit
      for (int i = 0; i <= TARGET_BUFFERS; i++)
         send_command(CMD_SEND, 12'hFFF, 16'h0000, 8'h00);
      send_command(CMD_COMPLETED, 12'hFFF, 16'h0001, 8'h00);
      send_command(CMD_COMPLETED, 12'hFFF, 16'hFFFF, 8'h00);   // more than in flight
      send_command(CMD_DISCONNECT, 12'hFFF, 16'h0000, 8'h00);  // first copy freed
      send_command(CMD_RESERVED_HI, 12'hFFF, 16'hFFFF, 8'hFF); // second copy still seen

      // random phases, each under its own buffer count; the last runs without gaps
      for (int phase = 0; phase < PHASES; phase++) begin
         write_buffers(phase_buffers[phase]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 30 == 0)
               idle_enabled = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
            issue_command(random_command());
         end
      end

      // drain and let any late result show up
      @(negedge clock);
      start        = 1'b0;
      idle_enabled = 1'b0;
      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (MAX_LINKS + 4) @(posedge clock);
      if (ledger.failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/cct_pkg.sv
hdl/cct_cell.sv
hdl/connection_credit_tracker_top.sv
tb/testbench.sv
